@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every clock edge outside reset.
`define ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_ON(label, prop, msg)
`define ASSERT_RST(label, prop, msg)
`endif

`endif

@@ rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int MAX_PATTERN_DEF     = 8;
  localparam int MAX_REPLACEMENT_DEF = 8;
  // Byte slots in one job; covers the largest legal value of either parameter.
  localparam int JOB_SLOTS           = 8;
  localparam int QUEUE_DEPTH         = 2;
  localparam int CFG_INDEX_W         = 4;

  localparam logic REQ_TEXT = 1'b0;
  localparam logic REQ_END  = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LEN       = 4'd0,
    REG_PATTERN_BYTES     = 4'd1,
    REG_REPLACEMENT_LEN   = 4'd2,
    REG_REPLACEMENT_BYTES = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        end_of_text;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  pattern_len;
    logic [63:0] pattern_bytes;
    logic [3:0]  replacement_len;
    logic [63:0] replacement_bytes;
  } cfg_t;

  // One queued job: n text bytes, then an end marker if eot is set.
  typedef struct packed {
    logic [JOB_SLOTS-1:0][7:0] bytes;
    logic [3:0]                n;
    logic                      eot;
  } job_t;

endpackage

@@ rtl/sfr_front.sv @@
// ----------------------------------------------------------------------------
// sfr_front
// Accepts input transactions, keeps the pending window and turns each item
// into at most one job of output bytes.
// ----------------------------------------------------------------------------
module sfr_front #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sfr_pkg::in_item_t in_data,
  input  sfr_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              job_valid,
  output sfr_pkg::job_t     job
);
  import sfr_pkg::*;

  logic [7:0] win      [MAX_PATTERN];
  logic [7:0] win_next [MAX_PATTERN];
  logic [7:0] comb_win [MAX_PATTERN];
  logic [3:0] cnt, cnt_next, cnt_inc;
  logic [3:0] l_eff, r_eff;
  logic       hit, need_job, accept;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign job_valid = accept && need_job;

  always_comb begin
    l_eff = (cfg.pattern_len > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : cfg.pattern_len;
    r_eff = (cfg.replacement_len > 4'(MAX_REPLACEMENT)) ?
            4'(MAX_REPLACEMENT) : cfg.replacement_len;
    cnt_inc = cnt + 4'd1;

    // Window with the new byte dropped in at the fill position
    for (int i = 0; i < MAX_PATTERN; i++) begin
      comb_win[i] = (cnt == 4'(i)) ? in_data.in_byte : win[i];
    end

    hit = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (4'(i) < l_eff && comb_win[i] != cfg.pattern_bytes[8*i +: 8]) hit = 1'b0;
    end

    job      = '0;
    need_job = 1'b0;
    cnt_next = cnt;
    win_next = win;

    if (in_data.req_type == REQ_END) begin
      for (int i = 0; i < MAX_PATTERN; i++) job.bytes[i] = win[i];
      job.n    = cnt;
      job.eot  = 1'b1;
      need_job = 1'b1;
      cnt_next = '0;
    end else if (cnt >= l_eff) begin
      // window already holds a full pattern length (length changed): dump it
      for (int i = 0; i < MAX_PATTERN; i++) job.bytes[i] = comb_win[i];
      job.n    = cnt_inc;
      need_job = 1'b1;
      cnt_next = '0;
    end else begin
      win_next = comb_win;
      if (cnt_inc < l_eff) begin
        cnt_next = cnt_inc;
      end else if (hit) begin
        for (int i = 0; i < JOB_SLOTS; i++) job.bytes[i] = cfg.replacement_bytes[8*i +: 8];
        job.n    = r_eff;
        need_job = (r_eff != 4'd0);
        cnt_next = '0;
      end else begin
        job.bytes[0] = comb_win[0];
        job.n        = 4'd1;
        need_job     = 1'b1;
        for (int i = 0; i + 1 < MAX_PATTERN; i++) win_next[i] = comb_win[i+1];
        cnt_next = cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win <= win_next;
    end
  end

endmodule

@@ rtl/sfr_queue.sv @@
// ----------------------------------------------------------------------------
// sfr_queue
// Small FIFO of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module sfr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             not_empty,
  output logic             full
);
  import sfr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(DEPTH));
  assign head      = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

@@ rtl/sfr_back.sv @@
// ----------------------------------------------------------------------------
// sfr_back
// Emits queued jobs' results one transaction a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module sfr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  sfr_pkg::job_t      q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output sfr_pkg::out_item_t out_data
);
  import sfr_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [3:0] idx;
  logic [3:0] total;
  logic       last, fire;
  logic [7:0] sel_byte;

  always_comb begin
    total    = cur.n + {3'd0, cur.eot};
    last     = (idx == total - 4'd1);
    sel_byte = '0;
    for (int i = 0; i < JOB_SLOTS; i++) begin
      if (idx == 4'(i)) sel_byte = cur.bytes[i];
    end
  end

  assign out_valid            = cur_valid;
  assign fire                 = out_valid && out_ready;
  assign out_data.byte_valid  = (idx < cur.n);
  assign out_data.out_byte    = out_data.byte_valid ? sel_byte : 8'd0;
  assign out_data.end_of_text = !out_data.byte_valid;
  assign out_data.last_of_run = last;
  assign q_pop                = q_not_empty && (!cur_valid || (fire && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (fire) begin
      if (last) cur_valid <= 1'b0;
      else      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
  end

endmodule

@@ rtl/stream_find_replace.sv @@
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming find-and-replace-all over a byte stream.
// ----------------------------------------------------------------------------
// An input item becomes at most one job of up to eight results in a
// two-entry queue; the output side sends one result per cycle while
// out_ready is high, and in_ready drops only while the job queue is full.
// With one result or fewer per item and out_ready held high the block runs
// at one byte per cycle. The pattern compare and window update sit in the
// front's combinational logic. Configure only while no transaction is in
// flight.
module stream_find_replace #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sfr_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sfr_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data
);
  import sfr_pkg::*;

  cfg_t cfg;
  job_t job, q_head;
  logic job_valid, q_full, q_not_empty, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_LEN:       cfg.pattern_len       <= cfg_data[3:0];
        REG_PATTERN_BYTES:     cfg.pattern_bytes     <= cfg_data;
        REG_REPLACEMENT_LEN:   cfg.replacement_len   <= cfg_data[3:0];
        REG_REPLACEMENT_BYTES: cfg.replacement_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  sfr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .q_full    (q_full),
    .job_valid (job_valid),
    .job       (job)
  );

  sfr_queue #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid),
    .push_data (job),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  sfr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

`include "assert_macros.svh"

  `ASSERT_ON(a_no_overflow, job_valid |-> !q_full, "job pushed into full queue")
  `ASSERT_ON(a_eot_last, (out_valid && out_data.end_of_text) |-> (out_data.last_of_run && !out_data.byte_valid), "end marker not last or carries a byte")
  `ASSERT_RST(a_reset_idle, rst |=> !out_valid, "output valid right after reset")

endmodule

@@ test/sfr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_checker
// Watches the input, output and register write channels of the find-and-
// replace block, predicts the output text from every accepted transaction
// and compares each accepted result field by field, in order.
// ----------------------------------------------------------------------------
module sfr_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  sfr_pkg::in_item_t               in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  sfr_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data,
  output int unsigned                     outstanding,
  output int unsigned                     errors
);
  import sfr_pkg::*;

  logic [3:0]  pat_len;
  logic [63:0] pat_bytes;
  logic [3:0]  rep_len;
  logic [63:0] rep_bytes;

  logic [7:0]  window [MAX_PATTERN_DEF];
  int unsigned held;

  out_item_t   expected_text [$];
  out_item_t   want;
  int unsigned fail_total = 0;

  function automatic out_item_t text_result(logic [7:0] b, logic is_byte, logic is_end);
    out_item_t r;
    r.out_byte    = b;
    r.byte_valid  = is_byte;
    r.end_of_text = is_end;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // One input transaction: update the window and queue the results it causes.
  function automatic void replace_step(in_item_t it);
    out_item_t   run [$];
    int unsigned plim;
    int unsigned rlim;
    int unsigned i;
    bit          hit;
    plim = (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : pat_len;
    rlim = (rep_len > MAX_REPLACEMENT_DEF) ? MAX_REPLACEMENT_DEF : rep_len;
    if (it.req_type == REQ_END) begin
      for (i = 0; i < held; i++) run.push_back(text_result(window[i], 1'b1, 1'b0));
      run.push_back(text_result(8'h00, 1'b0, 1'b1));
      held = 0;
    end else if (held >= plim) begin
      // window already at or past the pattern length: flush it, no compare
      for (i = 0; i < held; i++) run.push_back(text_result(window[i], 1'b1, 1'b0));
      run.push_back(text_result(it.in_byte, 1'b1, 1'b0));
      held = 0;
    end else begin
      window[held] = it.in_byte;
      held++;
      if (held == plim) begin
        hit = 1'b1;
        for (i = 0; i < plim; i++)
          if (window[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          for (i = 0; i < rlim; i++)
            run.push_back(text_result(rep_bytes[8*i +: 8], 1'b1, 1'b0));
          held = 0;
        end else begin
          run.push_back(text_result(window[0], 1'b1, 1'b0));
          for (i = 1; i < held; i++) window[i-1] = window[i];
          held--;
        end
      end
    end
    if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
    foreach (run[k]) expected_text.push_back(run[k]);
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] got);
    if (got !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got);
      fail_total++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pat_len   = '0;
      pat_bytes = '0;
      rep_len   = '0;
      rep_bytes = '0;
      held      = 0;
      expected_text.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected result transaction: out_byte %0h", out_data.out_byte);
          fail_total++;
        end else begin
          want = expected_text.pop_front();
          check_field("out_byte", want.out_byte, out_data.out_byte);
          check_field("byte_valid", want.byte_valid, out_data.byte_valid);
          check_field("end_of_text", want.end_of_text, out_data.end_of_text);
          check_field("last_of_run", want.last_of_run, out_data.last_of_run);
        end
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PATTERN_LEN:       pat_len   = cfg_data[3:0];
          REG_PATTERN_BYTES:     pat_bytes = cfg_data;
          REG_REPLACEMENT_LEN:   rep_len   = cfg_data[3:0];
          REG_REPLACEMENT_BYTES: rep_bytes = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) replace_step(in_data);
    end
    outstanding <= expected_text.size();
    errors      <= fail_total;
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the find-and-replace block with directed text around the length
// extremes, window flushes and deleting matches, then with random patterns
// and text under random stalls on both sides; sfr_checker does the compare.
// ----------------------------------------------------------------------------
module tb;
  import sfr_pkg::*;

  localparam int LIMIT       = 500_000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN       = 16;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 32;
  localparam int LEN_MAX     = 15;                     // largest 4-bit length value
  localparam int IDX_MAX     = (1 << CFG_INDEX_W) - 1;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  in_item_t               in_data   = '0;
  logic                   out_ready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0]            cfg_data  = '0;
  logic                   in_ready;
  logic                   out_valid;
  logic                   cfg_ready;
  out_item_t              out_data;

  int unsigned outstanding;
  int unsigned errors;
  int unsigned cycle_count   = 0;
  int unsigned hold_requests = 0;
  bit          no_gaps       = 1'b0;

  always #5 clk = ~clk;

  stream_find_replace i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sfr_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .errors      (errors)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("** stream_find_replace: FAILED **");
      $finish;
    end
  end

  // Output side: random ready pattern, plus a long hold-off on request.
  initial begin
    int unsigned holds_served;
    int          r;
    holds_served = 0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_requests != holds_served) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (r < 92) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(8, 30)) @(posedge clk);
        end
      end
    end
  end

  task automatic gap_before_item();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(in_item_t it);
    gap_before_item();
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item({REQ_TEXT, b});
  endtask

  // the byte field is don't-care on end of text, so fill it with noise
  task automatic send_end();
    send_item({REQ_END, 8'($urandom)});
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(logic [3:0] plen, logic [63:0] pat, logic [3:0] rlen,
                           logic [63:0] rep, bit stray);
    if (stray)
      write_reg(CFG_INDEX_W'($urandom_range(int'(REG_REPLACEMENT_BYTES) + 1, IDX_MAX)),
                {$urandom, $urandom});
    write_reg(REG_PATTERN_LEN, 64'(plen));
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_REPLACEMENT_LEN, 64'(rlen));
    write_reg(REG_REPLACEMENT_BYTES, rep);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every expected result, then let any zero-result work drain.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [3:0] pick_len(int lim);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 4'd0;
    if (r == 1) return 4'(lim);
    if (r == 2) return 4'($urandom_range(lim + 1, LEN_MAX));
    return 4'($urandom_range(1, lim - 1));
  endfunction

  task automatic random_phase(int ph);
    logic [3:0]  plen;
    logic [3:0]  rlen;
    logic [63:0] pat;
    logic [63:0] rep;
    logic [7:0]  base;
    logic [7:0]  b;
    int          eff;
    int          sent;
    int          r;
    int          j;
    // small alphabet so that text and pattern collide often
    base = 8'($urandom);
    for (j = 0; j < 8; j++) pat[8*j +: 8] = base + 8'($urandom_range(0, 2));
    rep  = {$urandom, $urandom};
    plen = (ph == 0) ? 4'(MAX_PATTERN_DEF) : (ph == 1) ? 4'd0 : pick_len(MAX_PATTERN_DEF);
    rlen = (ph == 0) ? 4'(MAX_REPLACEMENT_DEF) : pick_len(MAX_REPLACEMENT_DEF);
    configure(plen, pat, rlen, rep, ph % 3 == 0);
    eff = (plen > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : plen;
    no_gaps = (ph == 2 || ph == 6);
    if (ph == 2) hold_requests <= hold_requests + 1;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (eff > 0 && r < 30) begin
        for (j = 0; j < eff; j++) begin
          b = pat[8*j +: 8];
          if (r < 6 && j == eff - 1) b = b + 8'd1;   // near miss on the last byte
          send_byte(b);
        end
        sent += eff;
      end else if (r < 37) begin
        send_end();
        sent++;
      end else if (r < 50) begin
        send_byte(8'($urandom));
        sent++;
      end else begin
        send_byte(base + 8'($urandom_range(0, 2)));
        sent++;
      end
    end
    no_gaps = 1'b0;
    settle();
  endtask

  initial begin
    int i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers at reset value: plain pass-through
    send_byte(8'h00);
    send_byte(8'hFF);
    send_end();
    settle();

    // "abc" -> eight bytes, with a stray write to an unused index
    configure(4'd3, 64'h636261, 4'(MAX_REPLACEMENT_DEF), 64'hFFEE_DDCC_BBAA_9988, 1'b1);
    send_byte(8'h78);
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(8'h63);
    send_byte(8'h61);
    send_byte(8'h62);
    send_end();
    settle();

    // oversized lengths saturate; five bytes stay pending
    configure(4'(LEN_MAX), 64'h0123_4567_89AB_CDEF, 4'(LEN_MAX), 64'hF0E1_D2C3_B4A5_9687,
              1'b0);
    for (i = 0; i < 5; i++) send_byte(8'h10 + 8'(i));
    settle();
    // shorter pattern now: the pending window is flushed with the new byte
    configure(4'd2, 64'h1111, 4'd1, 64'h22, 1'b0);
    send_byte(8'h33);
    settle();

    // empty replacement deletes the match
    configure(4'd2, 64'hFF00, 4'd0, 64'h0, 1'b0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_end();
    settle();

    // zero pattern length with bytes still pending
    configure(4'd4, 64'h0, 4'd0, 64'h0, 1'b0);
    send_byte(8'h12);
    send_byte(8'h34);
    settle();
    configure(4'd0, 64'h0, 4'd3, 64'h0, 1'b0);
    send_byte(8'h56);
    settle();

    for (i = 0; i < PHASES; i++) random_phase(i);

    send_end();
    settle();

    if (errors == 0) $display("** stream_find_replace: PASSED **");
    else $display("** stream_find_replace: FAILED **");
    $finish;
  end

endmodule
